### src/jsu_pkg.sv
// types, constants and helper functions of the json string unescaper
package jsu_pkg;

  typedef enum logic [3:0] {
    PH_WAIT   = 4'd0,
    PH_BODY   = 4'd1,
    PH_ESC    = 4'd2,
    PH_HEX    = 4'd3,
    PH_SUR_BS = 4'd4,
    PH_SUR_U  = 4'd5,
    PH_LOWHEX = 4'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_NO_OPEN    = 4'd1,
    ERR_UNTERM     = 4'd2,
    ERR_ESC_CUT    = 4'd3,
    ERR_BAD_ESC    = 4'd4,
    ERR_BAD_HEX    = 4'd5,
    ERR_BAD_LOW    = 4'd6,
    ERR_MISS_LOW   = 4'd7,
    ERR_STRAY_LOW  = 4'd8,
    ERR_CONTROL    = 4'd9
  } err_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    err_t       error_code;
  } res_t;

  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    logic [2:0]              count;
    res_t [MAX_RES-1:0]      item;
  } bundle_t;

  localparam logic [7:0]  CH_QUOTE   = 8'h22;
  localparam logic [7:0]  CH_BSLASH  = 8'h5C;
  localparam logic [7:0]  CH_U       = 8'h75;
  localparam logic [7:0]  CTRL_LIMIT = 8'h20;
  localparam logic [15:0] HI_FIRST   = 16'hD800;
  localparam logic [15:0] HI_LAST    = 16'hDBFF;
  localparam logic [15:0] LO_FIRST   = 16'hDC00;
  localparam logic [15:0] LO_LAST    = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // bit 4 set when the byte is no hex digit
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) v = 5'(c - 8'h30);
    else if (c inside {[8'h61:8'h66]}) v = 5'(c - 8'h61 + 8'd10);
    else if (c inside {[8'h41:8'h46]}) v = 5'(c - 8'h41 + 8'd10);
    return v;
  endfunction

  // bit 8 set when the escape letter is not a simple escape
  function automatic logic [8:0] simple_escape(logic [7:0] e);
    logic [8:0] b;
    case (e)
      8'h22:   b = 9'h022;
      8'h5C:   b = 9'h05C;
      8'h2F:   b = 9'h02F;
      8'h62:   b = 9'h008;
      8'h66:   b = 9'h00C;
      8'h6E:   b = 9'h00A;
      8'h72:   b = 9'h00D;
      8'h74:   b = 9'h009;
      default: b = 9'h100;
    endcase
    return b;
  endfunction

endpackage

### src/jsu_if.sv
// request channel interfaces for input bytes and decoded results
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [3:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output kind, output error_code,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input error_code,
                  input last, output ready);
endinterface

### src/jsu_decode.sv
// escape decoder: parse state and the result bundle for one input byte
module jsu_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          data_byte,
  input  logic                end_of_input,
  output jsu_pkg::bundle_t    bundle
);

  jsu_pkg::phase_t phase, phase_next;
  logic [15:0]     acc, acc_next;
  logic [1:0]      cnt, cnt_next;
  logic [9:0]      hs, hs_next;

  logic [4:0]      digit;
  logic            dig_ok;
  logic [15:0]     acc_shift;
  logic            full;
  logic            is_hi, is_lo;
  logic [20:0]     cp_pair;
  logic [8:0]      esc;

  function automatic jsu_pkg::res_t data_res(logic [7:0] b);
    jsu_pkg::res_t r;
    r.out_byte   = b;
    r.kind       = jsu_pkg::KIND_DATA;
    r.error_code = jsu_pkg::ERR_NONE;
    return r;
  endfunction

  function automatic jsu_pkg::bundle_t one(jsu_pkg::res_t r);
    jsu_pkg::bundle_t b;
    b         = '0;
    b.count   = 3'd1;
    b.item[0] = r;
    return b;
  endfunction

  function automatic jsu_pkg::bundle_t fail_b(jsu_pkg::err_t code);
    jsu_pkg::res_t r;
    r.out_byte   = 8'h00;
    r.kind       = jsu_pkg::KIND_ERROR;
    r.error_code = code;
    return one(r);
  endfunction

  function automatic jsu_pkg::bundle_t utf8(logic [20:0] cp);
    jsu_pkg::bundle_t b;
    b = '0;
    if (cp <= 21'h7F) begin
      b.count   = 3'd1;
      b.item[0] = data_res(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      b.count   = 3'd2;
      b.item[0] = data_res({3'b110, cp[10:6]});
      b.item[1] = data_res({2'b10, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      b.count   = 3'd3;
      b.item[0] = data_res({4'b1110, cp[15:12]});
      b.item[1] = data_res({2'b10, cp[11:6]});
      b.item[2] = data_res({2'b10, cp[5:0]});
    end else begin
      b.count   = 3'd4;
      b.item[0] = data_res({5'b11110, cp[20:18]});
      b.item[1] = data_res({2'b10, cp[17:12]});
      b.item[2] = data_res({2'b10, cp[11:6]});
      b.item[3] = data_res({2'b10, cp[5:0]});
    end
    return b;
  endfunction

  assign digit     = jsu_pkg::hex_value(data_byte);
  assign dig_ok    = !end_of_input && !digit[4];
  assign acc_shift = {acc[11:0], digit[3:0]};
  assign full      = (cnt == 2'd3);
  assign is_hi     = (acc_shift >= jsu_pkg::HI_FIRST) && (acc_shift <= jsu_pkg::HI_LAST);
  assign is_lo     = (acc_shift >= jsu_pkg::LO_FIRST) && (acc_shift <= jsu_pkg::LO_LAST);
  assign cp_pair   = jsu_pkg::SUPP_BASE + {1'b0, hs, acc_shift[9:0]};
  assign esc       = jsu_pkg::simple_escape(data_byte);

  // next state
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    cnt_next   = cnt;
    hs_next    = hs;
    case (phase)
      jsu_pkg::PH_WAIT: begin
        if (!end_of_input && data_byte == jsu_pkg::CH_QUOTE) phase_next = jsu_pkg::PH_BODY;
      end
      jsu_pkg::PH_BODY: begin
        if (end_of_input || data_byte == jsu_pkg::CH_QUOTE || data_byte < jsu_pkg::CTRL_LIMIT)
        begin
          phase_next = jsu_pkg::PH_WAIT;
        end else if (data_byte == jsu_pkg::CH_BSLASH) begin
          phase_next = jsu_pkg::PH_ESC;
        end
      end
      jsu_pkg::PH_ESC: begin
        if (end_of_input) begin
          phase_next = jsu_pkg::PH_WAIT;
        end else if (data_byte == jsu_pkg::CH_U) begin
          phase_next = jsu_pkg::PH_HEX;
          acc_next   = '0;
          cnt_next   = '0;
        end else if (esc[8]) begin
          phase_next = jsu_pkg::PH_WAIT;
        end else begin
          phase_next = jsu_pkg::PH_BODY;
        end
      end
      jsu_pkg::PH_HEX, jsu_pkg::PH_LOWHEX: begin
        if (!dig_ok) begin
          phase_next = jsu_pkg::PH_WAIT;
          acc_next   = '0;
          cnt_next   = '0;
          hs_next    = '0;
        end else if (!full) begin
          acc_next = acc_shift;
          cnt_next = cnt + 2'd1;
        end else begin
          acc_next = '0;
          cnt_next = '0;
          if (phase == jsu_pkg::PH_HEX) begin
            if (is_hi) begin
              hs_next    = acc_shift[9:0];
              phase_next = jsu_pkg::PH_SUR_BS;
            end else if (is_lo) begin
              phase_next = jsu_pkg::PH_WAIT;
              hs_next    = '0;
            end else begin
              phase_next = jsu_pkg::PH_BODY;
            end
          end else begin
            hs_next    = '0;
            phase_next = is_lo ? jsu_pkg::PH_BODY : jsu_pkg::PH_WAIT;
          end
        end
      end
      jsu_pkg::PH_SUR_BS: begin
        if (!end_of_input && data_byte == jsu_pkg::CH_BSLASH) begin
          phase_next = jsu_pkg::PH_SUR_U;
        end else begin
          phase_next = jsu_pkg::PH_WAIT;
          acc_next   = '0;
          cnt_next   = '0;
          hs_next    = '0;
        end
      end
      jsu_pkg::PH_SUR_U: begin
        if (!end_of_input && data_byte == jsu_pkg::CH_U) begin
          phase_next = jsu_pkg::PH_LOWHEX;
          acc_next   = '0;
          cnt_next   = '0;
        end else begin
          phase_next = jsu_pkg::PH_WAIT;
          acc_next   = '0;
          cnt_next   = '0;
          hs_next    = '0;
        end
      end
      default: begin
        phase_next = jsu_pkg::PH_WAIT;
        acc_next   = '0;
        cnt_next   = '0;
        hs_next    = '0;
      end
    endcase
  end

  // results of this byte
  always_comb begin
    bundle = '0;
    case (phase)
      jsu_pkg::PH_WAIT: begin
        if (end_of_input || data_byte != jsu_pkg::CH_QUOTE) bundle = fail_b(jsu_pkg::ERR_NO_OPEN);
      end
      jsu_pkg::PH_BODY: begin
        if (end_of_input) begin
          bundle = fail_b(jsu_pkg::ERR_UNTERM);
        end else if (data_byte == jsu_pkg::CH_QUOTE) begin
          bundle = one('{out_byte: 8'h00, kind: jsu_pkg::KIND_END,
                         error_code: jsu_pkg::ERR_NONE});
        end else if (data_byte == jsu_pkg::CH_BSLASH) begin
          bundle = '0;
        end else if (data_byte < jsu_pkg::CTRL_LIMIT) begin
          bundle = fail_b(jsu_pkg::ERR_CONTROL);
        end else begin
          bundle = one(data_res(data_byte));
        end
      end
      jsu_pkg::PH_ESC: begin
        if (end_of_input) bundle = fail_b(jsu_pkg::ERR_ESC_CUT);
        else if (data_byte == jsu_pkg::CH_U) bundle = '0;
        else if (esc[8]) bundle = fail_b(jsu_pkg::ERR_BAD_ESC);
        else bundle = one(data_res(esc[7:0]));
      end
      jsu_pkg::PH_HEX: begin
        if (!dig_ok) bundle = fail_b(jsu_pkg::ERR_BAD_HEX);
        else if (!full || is_hi) bundle = '0;
        else if (is_lo) bundle = fail_b(jsu_pkg::ERR_STRAY_LOW);
        else bundle = utf8({5'b0, acc_shift});
      end
      jsu_pkg::PH_LOWHEX: begin
        if (!dig_ok) bundle = fail_b(jsu_pkg::ERR_BAD_HEX);
        else if (!full) bundle = '0;
        else if (is_lo) bundle = utf8(cp_pair);
        else bundle = fail_b(jsu_pkg::ERR_BAD_LOW);
      end
      jsu_pkg::PH_SUR_BS: begin
        if (end_of_input || data_byte != jsu_pkg::CH_BSLASH) begin
          bundle = fail_b(jsu_pkg::ERR_MISS_LOW);
        end
      end
      jsu_pkg::PH_SUR_U: begin
        if (end_of_input || data_byte != jsu_pkg::CH_U) bundle = fail_b(jsu_pkg::ERR_MISS_LOW);
      end
      default: bundle = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jsu_pkg::PH_WAIT;
      acc   <= '0;
      cnt   <= '0;
      hs    <= '0;
    end else if (take) begin
      phase <= phase_next;
      acc   <= acc_next;
      cnt   <= cnt_next;
      hs    <= hs_next;
    end
  end

endmodule

### src/json_string_unescape_utf8_top.sv
// top level of the json string unescaper with utf-8 output
//
//   channel  | dir | payload
//   in_ch    | in  | data_byte[7:0], end_of_input
//   out_ch   | out | out_byte[7:0], kind[1:0], error_code[3:0], last
//
// one input byte is taken per cycle while the bundle register is free; its results (none to four) go
// into a bundle register and leave through an output register at one result per cycle while out_ch is
// ready, so a byte giving more than one result holds the input until its last result is loaded
// rst is synchronous and clears parse state and the valid flags of the bundle and the output register
// a stalled out_ch still lets one more bundle be decoded behind the waiting result
module json_string_unescape_utf8_top (
  input  logic             clk,
  input  logic             rst,
  jsu_in_if.sink           in_ch,
  jsu_out_if.source        out_ch
);

  jsu_pkg::bundle_t dec_bundle;
  jsu_pkg::bundle_t b_bundle;
  logic             b_valid;
  logic [1:0]       b_idx;
  logic             b_last_item;
  logic             b_free;
  logic             o_load;
  logic             take;

  logic             o_valid;
  jsu_pkg::res_t    o_res;
  logic             o_last;

  assign b_last_item = ({1'b0, b_idx} == b_bundle.count - 3'd1);
  assign o_load      = b_valid && (!o_valid || out_ch.ready);
  assign b_free      = !b_valid || (o_load && b_last_item);
  assign in_ch.ready = b_free;
  assign take        = in_ch.valid && b_free;

  jsu_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .data_byte    (in_ch.data_byte),
    .end_of_input (in_ch.end_of_input),
    .bundle       (dec_bundle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      b_idx   <= '0;
    end else if (take) begin
      b_valid <= (dec_bundle.count != 3'd0);
      b_idx   <= '0;
    end else if (o_load) begin
      if (b_last_item) begin
        b_valid <= 1'b0;
      end else begin
        b_idx <= b_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_bundle <= dec_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (o_load) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_res  <= b_bundle.item[b_idx];
      o_last <= b_last_item;
    end
  end

  assign out_ch.valid      = o_valid;
  assign out_ch.out_byte   = o_res.out_byte;
  assign out_ch.kind       = o_res.kind;
  assign out_ch.error_code = o_res.error_code;
  assign out_ch.last       = o_last;

`ifndef SYNTHESIS
  a_idx_in_bundle: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> ({1'b0, b_idx} < b_bundle.count))
    else $error("bundle index beyond result count");

  a_data_no_code: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_res.kind != jsu_pkg::KIND_ERROR) |-> (o_res.error_code == jsu_pkg::ERR_NONE))
    else $error("error code on a non-error result");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_res.kind == jsu_pkg::KIND_ERROR) |-> (o_last && o_res.out_byte == 8'h00))
    else $error("error result not final or carries a byte");

  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_ch.ready)
    else $error("input not ready after reset");
`endif

endmodule

### tb/jsu_unescape_checker.sv
// checker for the json string unescaper: decodes accepted bytes and compares the results
`timescale 1ns / 100ps
module jsu_unescape_checker (
  input  logic clk,
  input  logic rst,
  jsu_in_if    in_ch,
  jsu_out_if   out_ch,
  output int   mismatches,
  output int   outstanding
);

  typedef struct {
    logic [7:0]     out_byte;
    jsu_pkg::kind_t kind;
    jsu_pkg::err_t  error_code;
    logic           last;
  } utf8_result_t;

  utf8_result_t    decoded_results[$];
  utf8_result_t    step_results[$];
  jsu_pkg::phase_t ph;
  logic [15:0]     hex_acc;
  logic [1:0]      digit_cnt;
  logic [9:0]      high_half;
  int              bad_count = 0;

  function automatic logic [4:0] nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h57);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h37);
    return 5'h10;
  endfunction

  task automatic clear_parse();
    ph        = jsu_pkg::PH_WAIT;
    hex_acc   = '0;
    digit_cnt = '0;
    high_half = '0;
  endtask

  task automatic emit(logic [7:0] b, jsu_pkg::kind_t k, jsu_pkg::err_t e);
    utf8_result_t r;
    r.out_byte   = b;
    r.kind       = k;
    r.error_code = e;
    r.last       = 1'b0;
    step_results = {step_results, r};
  endtask

  task automatic emit_error(jsu_pkg::err_t e);
    clear_parse();
    emit(8'h00, jsu_pkg::KIND_ERROR, e);
  endtask

  task automatic emit_data(logic [7:0] b);
    emit(b, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
  endtask

  task automatic emit_code_point(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      emit_data(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      emit_data({3'b110, cp[10:6]});
      emit_data({2'b10, cp[5:0]});
    end else if (cp <= 21'hFFFF) begin
      emit_data({4'b1110, cp[15:12]});
      emit_data({2'b10, cp[11:6]});
      emit_data({2'b10, cp[5:0]});
    end else begin
      emit_data({5'b11110, cp[20:18]});
      emit_data({2'b10, cp[17:12]});
      emit_data({2'b10, cp[11:6]});
      emit_data({2'b10, cp[5:0]});
    end
  endtask

  task automatic decode_byte(logic [7:0] c, logic eoi);
    logic [4:0]  d;
    logic [15:0] v;
    step_results.delete();
    case (ph)
      jsu_pkg::PH_WAIT: begin
        if (!eoi && c == jsu_pkg::CH_QUOTE) ph = jsu_pkg::PH_BODY;
        else emit_error(jsu_pkg::ERR_NO_OPEN);
      end
      jsu_pkg::PH_BODY: begin
        if (eoi) begin
          emit_error(jsu_pkg::ERR_UNTERM);
        end else if (c == jsu_pkg::CH_QUOTE) begin
          clear_parse();
          emit(8'h00, jsu_pkg::KIND_END, jsu_pkg::ERR_NONE);
        end else if (c == jsu_pkg::CH_BSLASH) begin
          ph = jsu_pkg::PH_ESC;
        end else if (c < jsu_pkg::CTRL_LIMIT) begin
          emit_error(jsu_pkg::ERR_CONTROL);
        end else begin
          emit_data(c);
        end
      end
      jsu_pkg::PH_ESC: begin
        if (eoi) begin
          emit_error(jsu_pkg::ERR_ESC_CUT);
        end else if (c == jsu_pkg::CH_U) begin
          ph        = jsu_pkg::PH_HEX;
          hex_acc   = '0;
          digit_cnt = '0;
        end else begin
          ph = jsu_pkg::PH_BODY;
          case (c)
            8'h22, 8'h5C, 8'h2F: emit_data(c);
            8'h62:   emit_data(8'h08);
            8'h66:   emit_data(8'h0C);
            8'h6E:   emit_data(8'h0A);
            8'h72:   emit_data(8'h0D);
            8'h74:   emit_data(8'h09);
            default: emit_error(jsu_pkg::ERR_BAD_ESC);
          endcase
        end
      end
      jsu_pkg::PH_HEX, jsu_pkg::PH_LOWHEX: begin
        d = eoi ? 5'h10 : nibble_of(c);
        if (d[4]) begin
          emit_error(jsu_pkg::ERR_BAD_HEX);
        end else begin
          v = {hex_acc[11:0], d[3:0]};
          if (digit_cnt != 2'd3) begin
            hex_acc = v;
            digit_cnt++;
          end else begin
            hex_acc   = '0;
            digit_cnt = '0;
            if (ph == jsu_pkg::PH_HEX) begin
              if (v >= jsu_pkg::HI_FIRST && v <= jsu_pkg::HI_LAST) begin
                high_half = v[9:0];
                ph        = jsu_pkg::PH_SUR_BS;
              end else if (v >= jsu_pkg::LO_FIRST && v <= jsu_pkg::LO_LAST) begin
                emit_error(jsu_pkg::ERR_STRAY_LOW);
              end else begin
                ph = jsu_pkg::PH_BODY;
                emit_code_point({5'b0, v});
              end
            end else if (v >= jsu_pkg::LO_FIRST && v <= jsu_pkg::LO_LAST) begin
              ph = jsu_pkg::PH_BODY;
              emit_code_point(jsu_pkg::SUPP_BASE + {1'b0, high_half, v[9:0]});
              high_half = '0;
            end else begin
              emit_error(jsu_pkg::ERR_BAD_LOW);
            end
          end
        end
      end
      jsu_pkg::PH_SUR_BS: begin
        if (!eoi && c == jsu_pkg::CH_BSLASH) ph = jsu_pkg::PH_SUR_U;
        else emit_error(jsu_pkg::ERR_MISS_LOW);
      end
      jsu_pkg::PH_SUR_U: begin
        if (!eoi && c == jsu_pkg::CH_U) begin
          ph        = jsu_pkg::PH_LOWHEX;
          hex_acc   = '0;
          digit_cnt = '0;
        end else begin
          emit_error(jsu_pkg::ERR_MISS_LOW);
        end
      end
      default: clear_parse();
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
    decoded_results = {decoded_results, step_results};
  endtask

  always @(posedge clk) begin : watch
    utf8_result_t want;
    if (rst) begin
      clear_parse();
      decoded_results.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte, in_ch.end_of_input);
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_results.size() == 0) begin
          if (bad_count < 10)
            $display("unexpected result: byte %02h kind %0d code %0d last %0b",
                     out_ch.out_byte, out_ch.kind, out_ch.error_code, out_ch.last);
          bad_count++;
        end else begin
          want = decoded_results.pop_front();
          if (out_ch.out_byte !== want.out_byte || out_ch.kind !== want.kind ||
              out_ch.error_code !== want.error_code || out_ch.last !== want.last) begin
            if (bad_count < 10)
              $display("mismatch: expected byte %02h kind %0d code %0d last %0b, got %s",
                       want.out_byte, want.kind, want.error_code, want.last,
                       $sformatf("byte %02h kind %0d code %0d last %0b", out_ch.out_byte,
                                 out_ch.kind, out_ch.error_code, out_ch.last));
            bad_count++;
          end
        end
      end
    end
    mismatches  <= bad_count;
    outstanding <= decoded_results.size();
  end

endmodule

### tb/json_string_unescape_utf8_top_tb.sv
// testbench top for the json string unescaper: stimulus, idling phases and verdict
`timescale 1ns / 100ps
module json_string_unescape_utf8_top_tb;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DIRECTED_ITEMS  = 25;
  localparam int ITEMS_PER_PHASE = 62;

  logic clk = 1'b0;
  logic rst;
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  int   sent         = 0;
  int   cycles       = 0;
  int   mismatches;
  int   outstanding;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  jsu_unescape_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] c, logic eoi);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.data_byte    <= c;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return ($urandom_range(1) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
  endfunction

  function automatic logic [9:0] pick_low10();
    case ($urandom_range(3))
      0:       return 10'h000;
      1:       return 10'h3FF;
      default: return 10'($urandom);
    endcase
  endfunction

  // code points off the surrogate range, weighted to the utf-8 length boundaries
  function automatic logic [15:0] pick_bmp();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'h007F;
      2:       return 16'h0080;
      3:       return 16'h07FF;
      4:       return 16'h0800;
      5:       return 16'hFFFF;
      6:       return 16'($urandom_range(16'h007F, 16'h0000));
      7:       return 16'($urandom_range(16'h07FF, 16'h0080));
      8:       return 16'($urandom_range(16'hD7FF, 16'h0800));
      default: return 16'($urandom_range(16'hFFFF, 16'hE000));
    endcase
  endfunction

  task automatic send_escape_u(logic [15:0] v);
    send_byte(jsu_pkg::CH_BSLASH, 1'b0);
    send_byte(jsu_pkg::CH_U, 1'b0);
    for (int k = 3; k >= 0; k--) send_byte(hex_char(v[4*k +: 4]), 1'b0);
  endtask

  task automatic send_random_string();
    int         n;
    logic [7:0] c;
    logic [15:0] v;
    if ($urandom_range(99) < 12) begin
      n = $urandom_range(3, 1);
      repeat (n) send_byte(8'($urandom), $urandom_range(7) == 0);
      return;
    end
    send_byte(jsu_pkg::CH_QUOTE, 1'b0);
    n = $urandom_range(6);
    repeat (n) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: begin
          do c = 8'($urandom_range(8'hFF, 8'h20));
          while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSLASH);
          send_byte(c, 1'b0);
        end
        6, 7, 8: begin
          send_byte(jsu_pkg::CH_BSLASH, 1'b0);
          case ($urandom_range(7))
            0:       c = "\"";
            1:       c = "\\";
            2:       c = "/";
            3:       c = "b";
            4:       c = "f";
            5:       c = "n";
            6:       c = "r";
            default: c = "t";
          endcase
          send_byte(c, 1'b0);
        end
        9, 10, 11, 12: send_escape_u(pick_bmp());
        13, 14, 15: begin
          send_escape_u({6'b110110, pick_low10()});
          send_escape_u({6'b110111, pick_low10()});
        end
        default: begin
          case ($urandom_range(8))
            0: send_byte(8'($urandom_range(8'h1F)), 1'b0);
            1: begin
              send_byte(jsu_pkg::CH_BSLASH, 1'b0);
              do c = 8'($urandom);
              while (c inside {8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h75});
              send_byte(c, 1'b0);
            end
            2: begin
              send_byte(jsu_pkg::CH_BSLASH, 1'b0);
              send_byte(jsu_pkg::CH_U, 1'b0);
              repeat ($urandom_range(3)) send_byte(hex_char(4'($urandom)), 1'b0);
              do c = 8'($urandom);
              while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
              send_byte(c, 1'b0);
            end
            3: send_escape_u({6'b110111, pick_low10()});
            4: begin
              send_escape_u({6'b110110, pick_low10()});
              do c = 8'($urandom); while (c == jsu_pkg::CH_BSLASH);
              send_byte(c, 1'b0);
            end
            5: begin
              send_escape_u({6'b110110, pick_low10()});
              send_byte(jsu_pkg::CH_BSLASH, 1'b0);
              do c = 8'($urandom); while (c == jsu_pkg::CH_U);
              send_byte(c, 1'b0);
            end
            6: begin
              send_escape_u({6'b110110, pick_low10()});
              v = $urandom_range(1) ? pick_bmp() : {6'b110110, pick_low10()};
              send_escape_u(v);
            end
            7: begin
              case ($urandom_range(2))
                0: ;
                1: send_byte(jsu_pkg::CH_BSLASH, 1'b0);
                default: begin
                  send_byte(jsu_pkg::CH_BSLASH, 1'b0);
                  send_byte(jsu_pkg::CH_U, 1'b0);
                  repeat ($urandom_range(3)) send_byte(hex_char(4'($urandom)), 1'b0);
                end
              endcase
              send_byte(8'($urandom), 1'b1);
            end
            default: begin
              send_escape_u({6'b110110, pick_low10()});
              if ($urandom_range(1)) send_byte(jsu_pkg::CH_BSLASH, 1'b0);
              send_byte(8'($urandom), 1'b1);
            end
          endcase
        end
      endcase
    end
    if ($urandom_range(9) != 0) send_byte(jsu_pkg::CH_QUOTE, 1'b0);
    else send_byte(8'($urandom), 1'b1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    rst                <= 1'b1;
    in_ch.valid        <= 1'b0;
    in_ch.data_byte    <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // stray byte and end of input before a quote, then string errors and \u0000
    send_byte("a", 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(jsu_pkg::CH_QUOTE, 1'b0);
    send_byte(8'h1F, 1'b0);
    send_byte(jsu_pkg::CH_QUOTE, 1'b0);
    send_byte(8'h00, 1'b1);
    send_str("\"\\");
    send_byte(8'h00, 1'b1);
    send_str("\"\\u0");
    send_byte(8'h00, 1'b1);
    send_str("\"\\x");
    send_str("\"\\u0000\"");

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 68;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 68;
        end
        default: begin
          tx_idle_pct  = 18;
          rx_stall_pct = 18;
        end
      endcase
      if (p != 0) drain();
      while (sent < DIRECTED_ITEMS + ITEMS_PER_PHASE * (p + 1)) send_random_string();
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
